// ----- rtl/core/tdclk_pkg.sv -----
// Package: item types and codes for the time-of-day clock core.
package tdclk_pkg;

    localparam logic [1:0] CMD_SECOND   = 2'd0;
    localparam logic [1:0] CMD_PRESS    = 2'd1;
    localparam logic [1:0] CMD_DEBOUNCE = 2'd2;
    localparam logic [1:0] CMD_BLINK    = 2'd3;

    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_MODE   = 3'd1;
    localparam logic [2:0] BTN_SELECT = 3'd2;
    localparam logic [2:0] BTN_DOWN   = 3'd3;
    localparam logic [2:0] BTN_UP     = 3'd4;

    localparam logic [1:0] FIELD_SEC  = 2'd0;
    localparam logic [1:0] FIELD_MIN  = 2'd1;
    localparam logic [1:0] FIELD_HOUR = 2'd2;

    localparam logic [1:0] BLANK_NONE = 2'd0;
    localparam logic [1:0] BLANK_HOUR = 2'd3;

    localparam logic [4:0] MAX_HOURS  = 5'd23;
    localparam logic [5:0] MAX_MINSEC = 6'd59;

    localparam logic [7:0] RESET_PERIOD = 8'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] buttons;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       set_mode_on;
        logic [1:0] blank_field;
        logic       action_fired;
    } res_item_t;

endpackage

// ----- rtl/core/time_of_day_clock_with_set_buttons_core.sv -----
// Top level: time-of-day clock with set buttons, debounce and blink control.
//
// Usage:
//   The command channel (cmd_valid / cmd_stall / cmd_item) carries one event
//   per item: second tick, button press edge, debounce tick with the held
//   button code, or half-second blink tick. Every accepted item yields
//   exactly one result item on the result channel (res_valid / res_stall /
//   res_item) with the current time, set mode, field to blank and whether a
//   debounced button action fired.
//   An accepted item's result is registered in the output register, or in
//   the skid register while the receiver stalls. One item per cycle is taken
//   unless stalled; state update is a single registered pass of short logic.
//   A two-entry result buffer (output register plus skid register) keeps
//   items flowing while the receiver stalls; cmd_stall rises only once both
//   entries hold results, and it is driven from a register.
//   cfg_write loads debounce_period from cfg_data; write it only while idle.
//   Reset (rst_n low, asynchronous) clears the time to 00:00:00, leaves set
//   mode, disarms the debouncer, sets the period to 5 and empties the buffer.
module time_of_day_clock_with_set_buttons_core
    import tdclk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item,
    input  logic      cfg_write,
    input  logic [7:0] cfg_data
);

    logic [7:0] period_reg;
    logic [4:0] hours_reg,   hours_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [5:0] seconds_reg, seconds_next;
    logic       set_mode_reg, set_mode_next;
    logic       armed_reg,    armed_next;
    logic [7:0] hold_reg,     hold_next;
    logic [1:0] field_reg,    field_next;
    logic [1:0] shown_reg,    shown_next;
    logic       phase_reg,    phase_next;

    logic       res_valid_reg;
    res_item_t  res_item_reg;
    logic       skid_valid_reg;
    res_item_t  skid_item_reg;

    logic       accept;
    logic [7:0] period_eff;
    logic [7:0] hold_inc;
    logic       fired;
    logic       step_up;
    logic [1:0] blank;
    res_item_t  new_item;

    assign accept     = cmd_valid && !skid_valid_reg;
    assign cmd_stall  = skid_valid_reg;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;
    assign period_eff = (period_reg == 8'd0) ? 8'd1 : period_reg;
    assign hold_inc   = hold_reg + 8'd1;

    always_comb
    begin
        hours_next    = hours_reg;
        minutes_next  = minutes_reg;
        seconds_next  = seconds_reg;
        set_mode_next = set_mode_reg;
        armed_next    = armed_reg;
        hold_next     = hold_reg;
        field_next    = field_reg;
        shown_next    = shown_reg;
        phase_next    = phase_reg;
        fired         = 1'b0;
        step_up       = (cmd_item.buttons != BTN_DOWN);

        unique case (cmd_item.command)
            CMD_SECOND:
            begin
                if (!set_mode_reg)
                begin
                    if (seconds_reg >= MAX_MINSEC)
                    begin
                        seconds_next = 6'd0;
                        if (minutes_reg >= MAX_MINSEC)
                        begin
                            minutes_next = 6'd0;
                            hours_next   = (hours_reg >= MAX_HOURS) ? 5'd0
                                                                    : hours_reg + 5'd1;
                        end
                        else
                        begin
                            minutes_next = minutes_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        seconds_next = seconds_reg + 6'd1;
                    end
                end
            end
            CMD_PRESS:
            begin
                armed_next = 1'b1;
            end
            CMD_DEBOUNCE:
            begin
                if (armed_reg)
                begin
                    if (cmd_item.buttons == BTN_NONE)
                    begin
                        armed_next = 1'b0;
                        hold_next  = 8'd0;
                    end
                    else if (hold_inc >= period_eff)
                    begin
                        hold_next = 8'd0;
                        fired     = 1'b1;
                        if (cmd_item.buttons == BTN_MODE)
                        begin
                            set_mode_next = !set_mode_reg;
                        end
                        else if (set_mode_reg)
                        begin
                            if (cmd_item.buttons == BTN_SELECT)
                            begin
                                field_next = (field_reg >= FIELD_HOUR) ? FIELD_SEC
                                                                       : field_reg + 2'd1;
                            end
                            else if (field_reg == FIELD_SEC)
                            begin
                                if (step_up)
                                    seconds_next = (seconds_reg >= MAX_MINSEC) ? 6'd0
                                                                               : seconds_reg + 6'd1;
                                else
                                    seconds_next = (seconds_reg == 6'd0 ||
                                                    seconds_reg > MAX_MINSEC)
                                                   ? MAX_MINSEC : seconds_reg - 6'd1;
                            end
                            else if (field_reg == FIELD_MIN)
                            begin
                                if (step_up)
                                    minutes_next = (minutes_reg >= MAX_MINSEC) ? 6'd0
                                                                               : minutes_reg + 6'd1;
                                else
                                    minutes_next = (minutes_reg == 6'd0 ||
                                                    minutes_reg > MAX_MINSEC)
                                                   ? MAX_MINSEC : minutes_reg - 6'd1;
                            end
                            else
                            begin
                                if (step_up)
                                    hours_next = (hours_reg >= MAX_HOURS) ? 5'd0
                                                                          : hours_reg + 5'd1;
                                else
                                    hours_next = (hours_reg == 5'd0 || hours_reg > MAX_HOURS)
                                                 ? MAX_HOURS : hours_reg - 5'd1;
                            end
                        end
                    end
                    else
                    begin
                        hold_next = hold_inc;
                    end
                end
            end
            CMD_BLINK:
            begin
                if (set_mode_reg)
                begin
                    phase_next = !phase_reg;
                    if (phase_reg)
                        shown_next = field_reg;
                end
            end
            default:
            begin
                armed_next = armed_reg;
            end
        endcase

        blank = BLANK_NONE;
        if (set_mode_next && !phase_next)
            blank = (shown_next > FIELD_HOUR) ? BLANK_HOUR : shown_next + 2'd1;

        new_item.hours        = hours_next;
        new_item.minutes      = minutes_next;
        new_item.seconds      = seconds_next;
        new_item.set_mode_on  = set_mode_next;
        new_item.blank_field  = blank;
        new_item.action_fired = fired;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= RESET_PERIOD;
            hours_reg    <= 5'd0;
            minutes_reg  <= 6'd0;
            seconds_reg  <= 6'd0;
            set_mode_reg <= 1'b0;
            armed_reg    <= 1'b0;
            hold_reg     <= 8'd0;
            field_reg    <= FIELD_SEC;
            shown_reg    <= FIELD_SEC;
            phase_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                period_reg <= cfg_data;
            if (accept)
            begin
                hours_reg    <= hours_next;
                minutes_reg  <= minutes_next;
                seconds_reg  <= seconds_next;
                set_mode_reg <= set_mode_next;
                armed_reg    <= armed_next;
                hold_reg     <= hold_next;
                field_reg    <= field_next;
                shown_reg    <= shown_next;
                phase_reg    <= phase_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
            begin
                res_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                res_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!res_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
                res_item_reg <= skid_item_reg;
            else if (accept)
                res_item_reg <= new_item;
        end
        else if (accept)
        begin
            skid_item_reg <= new_item;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry held while output register empty");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hours_reg <= MAX_HOURS && minutes_reg <= MAX_MINSEC && seconds_reg <= MAX_MINSEC)
        else $error("time of day out of range");

    a_field_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg != 2'd3 && shown_reg != 2'd3)
        else $error("field select holds an unused code");

    a_blank_in_set_mode: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.blank_field != BLANK_NONE |-> res_item_reg.set_mode_on)
        else $error("field blanked outside set mode");

    a_fire_on_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fired |-> cmd_item.command == CMD_DEBOUNCE && armed_reg)
        else $error("action fired without an armed debounce tick");

endmodule
